// ----- src/polyline_arc_length_lookup_defines.svh -----
// assertion macros
`ifndef POLYLINE_ARC_LENGTH_LOOKUP_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_LOOKUP_DEFINES_SVH
`define PAL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PAL_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/pal_pkg.sv -----
`default_nettype none
package pal_pkg;
    localparam int DW = 40;
    localparam int LW = 39;
    localparam int VW = 18;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic CFG_CLOSED = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;
    localparam logic signed [DW-1:0] DIST_LIMIT = 40'sd65536000000;
    localparam logic signed [DW-1:0] S40_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [DW-1:0] S40_MIN = -40'sh8000000000;

    typedef struct packed {
        logic clear;
        logic append;
        logic load;
        logic mod_step;
        logic srch_step;
        logic rd;
        logic mul;
        logic fin;
        logic [5:0] bit_idx;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic need_mod;
    } sts_t;
endpackage
`default_nettype wire

// ----- src/pal_datapath.sv -----
`default_nettype none
`include "polyline_arc_length_lookup_defines.svh"
module pal_datapath
    import pal_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    output sts_t sts,
    input  wire logic closed_loop,
    input  wire logic [LW-1:0] start_offset,
    input  wire logic signed [DW-1:0] in_sx, in_sy, in_sz,
    input  wire logic signed [VW-1:0] in_dx, in_dy, in_dz,
    input  wire logic [LW-1:0] in_len,
    input  wire logic signed [DW-1:0] in_q,
    output logic [5:0] o_idx,
    output logic signed [DW-1:0] o_px, o_py, o_pz,
    output logic signed [VW-1:0] o_tx, o_ty, o_tz,
    output logic signed [DW-1:0] o_wd,
    output logic [1:0] o_st
);
    logic signed [DW-1:0] mem_sx [MAX_SEGMENTS];
    logic signed [DW-1:0] mem_sy [MAX_SEGMENTS];
    logic signed [DW-1:0] mem_sz [MAX_SEGMENTS];
    logic signed [VW-1:0] mem_dx [MAX_SEGMENTS];
    logic signed [VW-1:0] mem_dy [MAX_SEGMENTS];
    logic signed [VW-1:0] mem_dz [MAX_SEGMENTS];
    logic [DW-1:0] mem_cum [MAX_SEGMENTS];

    logic [CW-1:0] count_reg;
    logic [DW-1:0] total_reg;
    logic signed [DW-1:0] d_reg;
    logic [1:0] st_reg;
    logic neg_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_src_reg;
    logic [AW-1:0] lo_reg, probe_reg;
    logic [DW-1:0] cum_rd_reg;
    logic [AW-1:0] seg_reg;
    logic signed [DW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [VW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0] r_reg;
    logic signed [DW+VW:0] px_reg, py_reg, pz_reg;

    // append
    logic [DW:0] tsum;
    assign tsum = {1'b0, total_reg} + {2'b0, in_len};
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem_sx[count_reg[AW-1:0]] <= in_sx;
            mem_sy[count_reg[AW-1:0]] <= in_sy;
            mem_sz[count_reg[AW-1:0]] <= in_sz;
            mem_dx[count_reg[AW-1:0]] <= in_dx;
            mem_dy[count_reg[AW-1:0]] <= in_dy;
            mem_dz[count_reg[AW-1:0]] <= in_dz;
            mem_cum[count_reg[AW-1:0]] <= total_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
            total_reg <= '0;
        end else if (cmd.append) begin
            count_reg <= count_reg + 1'b1;
            total_reg <= (tsum > {1'b0, S40_MAX}) ? S40_MAX : tsum[DW-1:0];
        end
    end
    assign sts.empty = (count_reg == '0);
    assign sts.full = (count_reg == CW'(MAX_SEGMENTS));

    // load: range check, then clamp or flag a modulo wrap
    logic signed [DW-1:0] q0, dl;
    logic [DW:0] endv;
    logic [1:0] st0;
    logic nm;
    logic signed [DW+1:0] offs;
    assign offs = {3'b0, start_offset};
    always_comb begin
        q0 = in_q;
        st0 = ST_OK;
        if (in_q < -DIST_LIMIT || in_q > DIST_LIMIT) begin
            q0 = '0;
            st0 = ST_RANGE;
        end
        endv = {2'b0, start_offset} + {1'b0, total_reg};
        if (endv > {1'b0, S40_MAX}) endv = {1'b0, S40_MAX};
        dl = q0;
        nm = 1'b0;
        if (start_offset != '0) begin
            if ($signed({{2{q0[DW-1]}}, q0}) < offs) dl = DW'(start_offset);
            else if ($signed({{2{q0[DW-1]}}, q0}) > $signed({1'b0, endv}))
                dl = endv[DW-1:0];
        end else if (closed_loop) begin
            if (total_reg == '0) dl = '0;
            else if (q0 < 0 || q0 > $signed(total_reg)) nm = 1'b1;
        end else begin
            if (q0 < 0) dl = '0;
            else if (q0 > $signed(total_reg)) dl = total_reg;
        end
    end
    assign sts.need_mod = nm;

    // restoring remainder of |q| by the total length, one bit a step
    logic [DW:0] trial;
    logic [DW-1:0] rem_sh;
    assign rem_sh = {rem_reg[DW-2:0], quo_src_reg[DW-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, total_reg};

    // binary search step
    logic [AW-1:0] cand;
    assign cand = lo_reg | (AW'(1) << cmd.bit_idx[$clog2(AW+1)-1:0]);

    logic signed [DW-1:0] off;
    assign off = r_reg - $signed(cum_rd_reg);

    function automatic logic signed [DW-1:0] place(input logic signed [DW-1:0] s,
                                                    input logic signed [DW+VW:0] p);
        logic signed [DW+VW+1:0] t;
        begin
            t = (DW+VW+2)'(s) + (DW+VW+2)'(p >>> 16);
            if (t > (DW+VW+2)'(S40_MAX)) place = S40_MAX;
            else if (t < (DW+VW+2)'(S40_MIN)) place = S40_MIN;
            else place = t[DW-1:0];
        end
    endfunction

    // fix up modulo result
    logic signed [DW-1:0] dfix;
    logic [DW-1:0] absd;
    always_comb begin
        absd = rem_reg;
        if (neg_reg) dfix = (absd == '0) ? '0 : $signed(total_reg - absd);
        else dfix = (absd == '0) ? $signed(total_reg) : $signed(absd);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg <= dl;
            r_reg <= dl - $signed({1'b0, start_offset});
            st_reg <= sts.empty ? ST_EMPTY : st0;
            neg_reg <= q0[DW-1];
            quo_src_reg <= q0[DW-1] ? DW'(-q0) : q0;
            rem_reg <= '0;
            lo_reg <= '0;
        end
        if (cmd.mod_step) begin
            rem_reg <= trial[DW] ? rem_sh : trial[DW-1:0];
            quo_src_reg <= {quo_src_reg[DW-2:0], 1'b0};
        end
        if (cmd.fin) begin
            d_reg <= dfix;
            r_reg <= dfix - $signed({1'b0, start_offset});
        end
        if (cmd.srch_step) begin
            probe_reg <= cand;
            cum_rd_reg <= mem_cum[cand];
        end
        if (cmd.rd) begin
            if (probe_reg != '0 && CW'(probe_reg) < count_reg &&
                $signed(cum_rd_reg) <= r_reg)
                lo_reg <= probe_reg;
            seg_reg <= lo_reg;
        end
        if (cmd.mul) begin
            cum_rd_reg <= mem_cum[lo_reg];
            sx_reg <= mem_sx[lo_reg];
            sy_reg <= mem_sy[lo_reg];
            sz_reg <= mem_sz[lo_reg];
            dx_reg <= mem_dx[lo_reg];
            dy_reg <= mem_dy[lo_reg];
            dz_reg <= mem_dz[lo_reg];
            seg_reg <= lo_reg;
        end
        if (cmd.bit_idx == 6'd63) begin
            px_reg <= (DW+VW+1)'(dx_reg * off) + 32768;
            py_reg <= (DW+VW+1)'(dy_reg * off) + 32768;
            pz_reg <= (DW+VW+1)'(dz_reg * off) + 32768;
        end
    end

    always_comb begin
        if (st_reg == ST_EMPTY) begin
            o_idx = '0; o_px = '0; o_py = '0; o_pz = '0;
            o_tx = '0; o_ty = '0; o_tz = '0; o_wd = '0;
        end else begin
            o_idx = 6'(seg_reg);
            o_px = place(sx_reg, px_reg);
            o_py = place(sy_reg, py_reg);
            o_pz = place(sz_reg, pz_reg);
            o_tx = dx_reg; o_ty = dy_reg; o_tz = dz_reg;
            o_wd = d_reg;
        end
        o_st = st_reg;
    end

    `PAL_ASSERT(a_count_max, aclk, aresetn, count_reg <= CW'(MAX_SEGMENTS), "count overflow")
    `PAL_ASSERT(a_full_nowrite, aclk, aresetn, sts.full |-> !cmd.append, "append when full")
    `PAL_ASSERT(a_total_pos, aclk, aresetn, !total_reg[DW-1], "total negative")
endmodule
`default_nettype wire

// ----- src/pal_ctrl.sv -----
`default_nettype none
`include "polyline_arc_length_lookup_defines.svh"
module pal_ctrl
    import pal_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [1:0] s_op,
    output logic m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MOD  = 7'b0000010,
        S_FIX  = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;
    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_op)
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_APPEND: cmd.append = !sts.full;
                        OP_QUERY: begin
                            cmd.load = 1'b1;
                            if (sts.need_mod && !sts.empty) begin
                                cnt_next = 6'(DW - 1);
                                state_next = S_MOD;
                            end else begin
                                cnt_next = 6'(AW - 1);
                                state_next = S_PROBE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == '0) state_next = S_FIX;
                else cnt_next = cnt_reg - 1'b1;
            end
            S_FIX: begin
                cmd.fin = 1'b1;
                cnt_next = 6'(AW - 1);
                state_next = S_PROBE;
            end
            S_PROBE: begin
                cmd.srch_step = 1'b1;
                cmd.bit_idx = cnt_reg;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.rd = 1'b1;
                if (cnt_reg == '0) state_next = S_MUL;
                else begin
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.bit_idx = 6'd63;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `PAL_ASSERT_RST(a_rst_idle, aclk, !aresetn |=> state_reg == S_IDLE, "not idle after reset")
    `PAL_ASSERT(a_onehot, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `PAL_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `PAL_ASSERT(a_no_accept_busy, aclk, aresetn, m_valid |-> !s_ready, "accept while busy")
endmodule
`default_nettype wire

// ----- src/polyline_arc_length_lookup.sv -----
// timing: clear/append take effect at the accepting edge; a query result is valid after
// the 6-step table search, preceded by the 40-step bit-serial remainder when the distance
// needs a modulo wrap; then the segment is read and the point is computed and registered
// throughput: one request at a time; a query blocks new requests until its result is taken;
// clear and append can be accepted every cycle while no query is in progress or waiting
// reset: aresetn synchronous active low clears control, count, total and config registers
`default_nettype none
module polyline_arc_length_lookup
    import pal_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic signed [39:0] s_start_x,
    input  wire logic signed [39:0] s_start_y,
    input  wire logic signed [39:0] s_start_z,
    input  wire logic signed [17:0] s_dir_x,
    input  wire logic signed [17:0] s_dir_y,
    input  wire logic signed [17:0] s_dir_z,
    input  wire logic [38:0] s_seg_len,
    input  wire logic signed [39:0] s_query_distance,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [5:0] m_seg_index,
    output logic signed [39:0] m_point_x,
    output logic signed [39:0] m_point_y,
    output logic signed [39:0] m_point_z,
    output logic signed [17:0] m_tangent_x,
    output logic signed [17:0] m_tangent_y,
    output logic signed [17:0] m_tangent_z,
    output logic signed [39:0] m_wrapped_distance,
    output logic [1:0] m_status,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic cfg_index,
    input  wire logic [38:0] cfg_data
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    cmd_t cmd;
    sts_t sts;
    logic closed_reg;
    logic [LW-1:0] offset_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg <= 1'b0;
            offset_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CLOSED: closed_reg <= cfg_data[0];
                CFG_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pal_ctrl #(.AW(AW)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .m_valid, .m_ready, .sts, .cmd
    );

    pal_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW), .CW(CW)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .closed_loop(closed_reg), .start_offset(offset_reg),
        .in_sx(s_start_x), .in_sy(s_start_y), .in_sz(s_start_z),
        .in_dx(s_dir_x), .in_dy(s_dir_y), .in_dz(s_dir_z),
        .in_len(s_seg_len), .in_q(s_query_distance),
        .o_idx(m_seg_index), .o_px(m_point_x), .o_py(m_point_y), .o_pz(m_point_z),
        .o_tx(m_tangent_x), .o_ty(m_tangent_y), .o_tz(m_tangent_z),
        .o_wd(m_wrapped_distance), .o_st(m_status)
    );
endmodule
`default_nettype wire
